// ===== design/lss_pkg.sv =====
// shared types and constants of the lottery slice scheduler
`timescale 1ns / 1ps

package lss_pkg;

  // default table depth
  localparam int unsigned MAX_JOBS_DEF = 8;

  // field widths
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned TICKET_W = 8;
  localparam int unsigned CLOCK_W  = 32;
  localparam int unsigned DIV_W    = 16;

  // register reset values
  localparam logic [15:0] QUANTUM_RST     = 16'd4;
  localparam logic [7:0]  TICKET_BASE_RST = 8'd10;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_SCHED = 1'b1
  } action_e;

  typedef enum logic {
    CFG_QUANTUM     = 1'b0,
    CFG_TICKET_BASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_SLICE = 2'd0,
    KIND_IDLE  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICKET,
    ST_SUM,
    ST_DECIDE,
    ST_MOD,
    ST_PICK,
    ST_SLICE,
    ST_REPORT,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]   arrival;
    logic [TIME_W-1:0]   burst;
    logic [TIME_W-1:0]   remaining;
    logic [TICKET_W-1:0] ticket;
  } job_entry_t;

endpackage

// ===== design/lottery_slice_scheduler.sv =====
// lottery slice scheduler top level: control sequencer, clock and result register
`timescale 1ns / 1ps

// Lottery slice scheduler over a table of MaxJobs jobs held in a one-port-write,
// registered-read memory. A load beat (action 0) computes the ticket count
// max(1, ticket_base / max(1, priority_level)) on the shared 16-step serial
// divider and writes the entry; it gives no result. A load to an index outside
// the table is dropped. A schedule beat (action 1) sweeps the table once to total
// the tickets of eligible jobs and find the earliest unfinished arrival, reduces
// the draw modulo that total on the divider, sweeps again until the running
// ticket sum passes the reduced draw, writes back the remaining time and presents
// the result. With no eligible job the result (idle gap or all done) follows the
// first sweep. One beat is worked on at a time. A finished result sits in an
// output register, so the next input beat is taken while it waits on out_stall_i.
// Configuration writes (index 0 quantum, index 1 ticket_base) are taken at any
// time but are meant for when the block is idle.

module lottery_slice_scheduler import lss_pkg::*; #(
  parameter int unsigned MaxJobs = MAX_JOBS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [2:0]  job_index_i,
  input  logic [15:0] arrival_i,
  input  logic [15:0] burst_i,
  input  logic [7:0]  priority_level_i,
  input  logic [15:0] draw_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  chosen_job_o,
  output logic [15:0] span_o,
  output logic        finished_o,
  output logic [31:0] turnaround_o,
  output logic [31:0] waiting_o,
  output logic [31:0] now_time_o
);

  localparam int unsigned IdxW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int unsigned CntW = $clog2(MaxJobs + 1);
  localparam int unsigned TotW = $clog2(MaxJobs * 255 + 1);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [15:0]         quantum_q;
  logic [7:0]          ticket_base_q;
  logic [CLOCK_W-1:0]  clock_q;
  logic [CntW-1:0]     cnt_q;
  logic                pv_q;        // read data valid this cycle
  logic [IdxW-1:0]     pidx_q;      // entry index of the read data
  logic [TotW-1:0]     total_q;
  logic                found_q;     // some job still unfinished
  logic [TIME_W-1:0]   earliest_q;
  logic [TotW-1:0]     pick_q;
  logic [TotW-1:0]     sum_q;
  logic [15:0]         draw_q;
  job_entry_t          sel_q;
  logic [IdxW-1:0]     sel_idx_q;
  logic [TIME_W-1:0]   slice_q;
  logic                fin_q;
  logic [TIME_W:0]     ab_q;        // arrival plus burst of the selected job
  logic [IdxW-1:0]     ld_idx_q;
  logic [TIME_W-1:0]   ld_arr_q;
  logic [TIME_W-1:0]   ld_bur_q;

  // result register
  logic                out_valid_q;
  kind_e               kind_q;
  logic [2:0]          chosen_q;
  logic [15:0]         span_q;
  logic                fin_out_q;
  logic [31:0]         ta_q;
  logic [31:0]         wt_q;
  logic [31:0]         now_q;

  // ---------------------------------------------------------------------------
  // handshake and shared decode
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic out_free;
  logic is_sched;
  logic idx_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_sched   = (action_e'(action_i) == ACT_SCHED);
  assign idx_ok     = (32'(job_index_i) < 32'(MaxJobs));

  // ---------------------------------------------------------------------------
  // table and divider
  // ---------------------------------------------------------------------------
  logic            tbl_we;
  logic [IdxW-1:0] tbl_waddr;
  job_entry_t      tbl_wentry;
  logic [IdxW-1:0] tbl_raddr;
  job_entry_t      rd_entry;

  lss_table #(
    .MaxJobs (MaxJobs),
    .IdxW    (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (tbl_we),
    .wr_addr_i  (tbl_waddr),
    .wr_entry_i (tbl_wentry),
    .rd_addr_i  (tbl_raddr),
    .rd_entry_o (rd_entry)
  );

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;

  lss_div #(
    .Width (DIV_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // ---------------------------------------------------------------------------
  // datapath decode on table read data
  // ---------------------------------------------------------------------------
  logic              elig;
  logic [TotW-1:0]   sum_nx;
  logic              hit;
  logic              last;
  logic              issue;
  logic [7:0]        pri_eff;
  logic [TICKET_W-1:0] ticket_new;
  logic [15:0]       q_eff;
  logic [TIME_W-1:0] slice_nx;
  logic [TIME_W-1:0] rem_nx;
  logic [CLOCK_W:0]  clock_sum;
  logic [CLOCK_W-1:0] clock_sat;
  logic [31:0]       ta_nx;
  logic [31:0]       wt_nx;

  always_comb begin
    // eligible: still needs time and has arrived
    elig   = (rd_entry.remaining != '0) &&
             ({16'b0, rd_entry.arrival} <= clock_q);
    sum_nx = sum_q + TotW'(rd_entry.ticket);
    hit    = pv_q && elig && (pick_q < sum_nx);
    last   = pv_q && (pidx_q == IdxW'(MaxJobs - 1));

    // priority of zero counts as one, ticket count at least one
    pri_eff    = (priority_level_i == 8'd0) ? 8'd1 : priority_level_i;
    ticket_new = (div_quo == '0) ? TICKET_W'(1) : div_quo[TICKET_W-1:0];

    // slice length and saturating clock advance
    q_eff     = (quantum_q == 16'd0) ? 16'd1 : quantum_q;
    slice_nx  = (q_eff < sel_q.remaining) ? q_eff : sel_q.remaining;
    rem_nx    = sel_q.remaining - slice_nx;
    clock_sum = {1'b0, clock_q} + {17'b0, slice_nx};
    clock_sat = clock_sum[CLOCK_W] ? '1 : clock_sum[CLOCK_W-1:0];

    // completion figures, from the already advanced clock
    ta_nx = clock_q - {16'b0, sel_q.arrival};
    wt_nx = (clock_q >= {15'b0, ab_q}) ? (clock_q - {15'b0, ab_q}) : 32'd0;
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_sched) begin
            state_d = ST_SUM;
          end else if (idx_ok) begin
            state_d = ST_TICKET;
          end
        end
      end
      ST_TICKET: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = (total_q != '0) ? ST_MOD : ST_EMPTY;
      end
      ST_MOD: begin
        if (div_done) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (hit) begin
          state_d = ST_SLICE;
        end
      end
      ST_SLICE: begin
        state_d = ST_REPORT;
      end
      ST_REPORT, ST_EMPTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    issue        = 1'b0;
    tbl_raddr    = '0;
    tbl_we       = 1'b0;
    tbl_waddr    = ld_idx_q;
    tbl_wentry   = '{arrival: ld_arr_q, burst: ld_bur_q, remaining: ld_bur_q,
                     ticket: ticket_new};
    div_start    = 1'b0;
    div_dividend = {8'b0, ticket_base_q};
    div_divisor  = {8'b0, pri_eff};
    case (state_q)
      ST_IDLE: begin
        div_start = in_acc && !is_sched && idx_ok;
      end
      ST_TICKET: begin
        tbl_we = div_done;
      end
      ST_SUM, ST_PICK: begin
        // sweep reads one entry per cycle
        issue     = (cnt_q != CntW'(MaxJobs));
        tbl_raddr = issue ? cnt_q[IdxW-1:0] : '0;
      end
      ST_DECIDE: begin
        div_start    = (total_q != '0);
        div_dividend = draw_q;
        div_divisor  = DIV_W'(total_q);
      end
      ST_SLICE: begin
        tbl_we               = 1'b1;
        tbl_waddr            = sel_idx_q;
        tbl_wentry           = sel_q;
        tbl_wentry.remaining = rem_nx;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      quantum_q     <= QUANTUM_RST;
      ticket_base_q <= TICKET_BASE_RST;
      clock_q       <= '0;
      cnt_q         <= '0;
      pv_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= issue;

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_QUANTUM:     quantum_q     <= cfg_wdata_i;
          CFG_TICKET_BASE: ticket_base_q <= cfg_wdata_i[7:0];
          default: begin
          end
        endcase
      end

      // sweep counter restarts outside the two sweeps
      if (issue) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (state_q != ST_SUM && state_q != ST_PICK) begin
        cnt_q <= '0;
      end

      // time moves on a granted slice or an idle jump
      if (state_q == ST_SLICE) begin
        clock_q <= clock_sat;
      end else if (state_q == ST_EMPTY && out_free && found_q) begin
        clock_q <= {16'b0, earliest_q};
      end

      if ((state_q == ST_REPORT || state_q == ST_EMPTY) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q[IdxW-1:0];

    if (in_acc) begin
      ld_idx_q   <= IdxW'(job_index_i);
      ld_arr_q   <= arrival_i;
      ld_bur_q   <= burst_i;
      draw_q     <= draw_i;
      total_q    <= '0;
      found_q    <= 1'b0;
      earliest_q <= '0;
    end

    // first sweep: eligible tickets and earliest unfinished arrival
    if (state_q == ST_SUM && pv_q) begin
      if (elig) begin
        total_q <= total_q + TotW'(rd_entry.ticket);
      end
      if (rd_entry.remaining != '0 && (!found_q || rd_entry.arrival < earliest_q)) begin
        earliest_q <= rd_entry.arrival;
        found_q    <= 1'b1;
      end
    end

    if (state_q == ST_MOD && div_done) begin
      pick_q <= div_rem[TotW-1:0];
      sum_q  <= '0;
    end

    // second sweep: running ticket sum against the reduced draw
    if (state_q == ST_PICK && pv_q && elig) begin
      sum_q <= sum_nx;
      if (hit) begin
        sel_q     <= rd_entry;
        sel_idx_q <= pidx_q;
      end
    end

    if (state_q == ST_SLICE) begin
      slice_q <= slice_nx;
      fin_q   <= (rem_nx == '0);
      ab_q    <= {1'b0, sel_q.arrival} + {1'b0, sel_q.burst};
    end

    if (state_q == ST_REPORT && out_free) begin
      kind_q    <= KIND_SLICE;
      chosen_q  <= 3'(sel_idx_q);
      span_q    <= slice_q;
      fin_out_q <= fin_q;
      ta_q      <= fin_q ? ta_nx : 32'd0;
      wt_q      <= fin_q ? wt_nx : 32'd0;
      now_q     <= clock_q;
    end else if (state_q == ST_EMPTY && out_free) begin
      kind_q    <= found_q ? KIND_IDLE : KIND_DONE;
      chosen_q  <= 3'd0;
      span_q    <= found_q ? (earliest_q - clock_q[15:0]) : 16'd0;
      fin_out_q <= 1'b0;
      ta_q      <= 32'd0;
      wt_q      <= 32'd0;
      now_q     <= found_q ? {16'b0, earliest_q} : clock_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign chosen_job_o = chosen_q;
  assign span_o       = span_q;
  assign finished_o   = fin_out_q;
  assign turnaround_o = ta_q;
  assign waiting_o    = wt_q;
  assign now_time_o   = now_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the divider is never restarted mid-operation
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // the selection sweep always lands on a job before it runs out of entries
  a_pick_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PICK && last) |-> hit)
    else $error("ticket walk found no job");

  // a new result only comes out of the two reporting states
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_REPORT || $past(state_q) == ST_EMPTY))
    else $error("result raised outside a reporting state");

  // scheduler time never runs backward
  a_clock_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> clock_q >= $past(clock_q))
    else $error("clock went backward");

endmodule

// ===== design/lss_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lss_div import lss_pkg::*; #(
  parameter int unsigned Width = DIV_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [Width-1:0] quotient_o,
  output logic [Width-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [Width-1:0] quo_q;
  logic [Width-1:0] rem_q;
  logic [Width-1:0] div_q;

  logic [Width:0]   rem_sh;
  logic [Width:0]   rem_sub;
  logic             ge;
  logic [Width-1:0] rem_nx;

  always_comb begin
    rem_sh  = {rem_q, quo_q[Width-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    ge      = rem_sh >= {1'b0, div_q};
    rem_nx  = ge ? rem_sub[Width-1:0] : rem_sh[Width-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[Width-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== design/lss_table.sv =====
// job table memory with per-entry valid bits, registered read
`timescale 1ns / 1ps

module lss_table import lss_pkg::*; #(
  parameter int unsigned MaxJobs = MAX_JOBS_DEF,
  parameter int unsigned IdxW    = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  job_entry_t      wr_entry_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output job_entry_t      rd_entry_o
);

  job_entry_t         mem_q [MaxJobs];
  logic [MaxJobs-1:0] vld_q;
  job_entry_t         rd_q;
  logic               rd_vld_q;

  // valid bits: an unloaded entry reads as finished
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_comb begin
    rd_entry_o = rd_q;
    if (!rd_vld_q) begin
      rd_entry_o.remaining = '0;
    end
  end

endmodule
